### sv/vsc_pkg.sv
package vsc_pkg;

   // silhouette store geometry
   localparam int MASK_SIDE   = 256;
   localparam int STORE_AW    = 16;
   localparam int STORE_DEPTH = MASK_SIDE * MASK_SIDE;

   // projection arithmetic
   localparam int COEF_W  = 32;
   localparam int GRID_W  = 10;
   localparam int PROD_W  = COEF_W + GRID_W + 1;
   localparam int SUM_W   = PROD_W + 1;
   localparam int NUM_W   = SUM_W + 2;
   localparam int DEN_W   = SUM_W + 1;
   localparam int QUO_W   = 9;
   localparam int REM_W   = DEN_W + QUO_W;
   localparam int DIV_STEPS = QUO_W;

   localparam int COEF_REGS = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int DIM_W = 9;
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MASK_SIDE);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_R0A  = 3'd0,
      CSR_COEF_R0B  = 3'd1,
      CSR_COEF_R1A  = 3'd2,
      CSR_COEF_R1B  = 3'd3,
      CSR_COEF_R2A  = 3'd4,
      CSR_COEF_R2B  = 3'd5,
      CSR_MASK_COLS = 3'd6,
      CSR_MASK_ROWS = 3'd7
   } vsc_csr_type;

   typedef struct packed {
      logic              req_type;
      logic [15:0]       mask_addr;
      logic              mask_bit;
      logic [GRID_W-1:0] voxel_x;
      logic [GRID_W-1:0] voxel_y;
      logic [GRID_W-1:0] voxel_z;
      logic [7:0]        voxel_in;
   } vsc_req_type;

   typedef struct packed {
      logic [7:0] voxel_out;
      logic       out_of_view;
      logic       depth_zero;
   } vsc_rsp_type;

   // per-transaction bookkeeping carried down the pipeline
   typedef struct packed {
      logic                carve;
      logic                dz;
      logic                oov;
      logic [STORE_AW-1:0] addr;
      logic                mask_bit;
      logic [7:0]          voxel;
   } vsc_tag_type;

endpackage

### sv/vsc_qdiv.sv
module vsc_qdiv import vsc_pkg::*; (
   input  logic                 clock,
   input  logic [DIV_STEPS:0]   load,
   input  logic                 num_neg,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [QUO_W-1:0]     quo,
   output logic                 over
);

   // stage 0 checks the quotient range, stages 1..QUO_W retire one bit each
   logic [REM_W-1:0] rem_ff  [DIV_STEPS:0];
   logic [DEN_W-1:0] den_ff  [DIV_STEPS:0];
   logic [QUO_W-1:0] quo_ff  [DIV_STEPS:0];
   logic             over_ff [DIV_STEPS:0];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rem_ff[0]  <= REM_W'(num);
         den_ff[0]  <= den;
         quo_ff[0]  <= '0;
         over_ff[0] <= num_neg || (REM_W'(num) >= {den, QUO_W'(0)});
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [REM_W-1:0] shifted;
      logic             ge;
      assign shifted = REM_W'(den_ff[k-1]) << (QUO_W - k);
      assign ge      = rem_ff[k-1] >= shifted;

      always_ff @(posedge clock) begin
         if (load[k]) begin
            rem_ff[k]  <= ge ? rem_ff[k-1] - shifted : rem_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= quo_ff[k-1] | (QUO_W'(ge) << (QUO_W - k));
            over_ff[k] <= over_ff[k-1];
         end
      end
   end

   assign quo  = quo_ff[DIV_STEPS];
   assign over = over_ff[DIV_STEPS];

endmodule

### sv/voxel_silhouette_carve_top.sv
// Silhouette carving engine (visual hull step).
// Channels:
//   req_*  : one transaction per request. req_type 0 stores one silhouette bit
//            at mask_addr, req_type 1 carves one voxel against the mask.
//   rsp_*  : one transaction per carve request, none for mask writes,
//            always in request order.
//   csr_*  : register writes (camera matrix rows, mask extent). Always ready;
//            write only while no request is in flight.
// Throughput: one request per cycle while rsp_ready is held high. The 17
//   stages are input register, multiply, row sums, sign normalize, range
//   check, nine quotient-bit steps, store address, silhouette store access
//   and output register.
// Mask writes travel the same pipe and update the store at the same stage
//   where carves read it, so writes and carves act in acceptance order.
// Reset clears all stage valids and the registers (mask extent 256x256);
//   the silhouette store itself is not cleared and must be written first.
// When the receiver stalls, bubbles collapse stage by stage; req_ready
//   drops only once the pipe is full up to the input register.
module voxel_silhouette_carve_top import vsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vsc_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vsc_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NS = 17;      // pipeline depth
   localparam int ST_SUM  = 3;
   localparam int ST_NORM = 4;
   localparam int ST_DIV0 = 5;
   localparam int ST_ADDR = ST_DIV0 + DIV_STEPS + 1;
   localparam int ST_MEM  = ST_ADDR + 1;

   // ---------------- configuration registers
   logic [CSR_DATA_W-1:0] coef_ff [COEF_REGS];
   logic [DIM_W-1:0]      cols_ff;
   logic [DIM_W-1:0]      rows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_REGS; i++) coef_ff[i] <= '0;
         cols_ff <= DIM_RESET;
         rows_ff <= DIM_RESET;
      end else if (csr_valid) begin
         case (csr_index) inside
            [CSR_COEF_R0A:CSR_COEF_R2B]: coef_ff[csr_index] <= csr_data;
            CSR_MASK_COLS:               cols_ff <= csr_data[DIM_W-1:0];
            CSR_MASK_ROWS:               rows_ff <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control
   logic [NS:1] valid_ff, valid_in, go, en;
   vsc_tag_type tag_ff [NS:2];
   vsc_tag_type tag_in [NS:2];

   always_comb begin
      for (int i = NS; i >= 1; i--) begin
         if (i == NS)
            go[i] = valid_ff[i] && rsp_ready;
         else if (i == ST_MEM)
            go[i] = valid_ff[i] && (!tag_ff[i].carve || !valid_ff[NS] || go[NS]);
         else
            go[i] = valid_ff[i] && (!valid_ff[i+1] || go[i+1]);
      end
      req_ready = !valid_ff[1] || go[1];
      en[1]     = req_valid && req_ready;
      valid_in[1] = en[1] || (valid_ff[1] && !go[1]);
      for (int i = 2; i <= NS; i++) begin
         en[i]       = go[i-1];
         valid_in[i] = go[i-1] || (valid_ff[i] && !go[i]);
      end
      // mask writes retire at the store stage and skip the output register
      en[NS]       = go[ST_MEM] && tag_ff[ST_MEM].carve;
      valid_in[NS] = en[NS] || (valid_ff[NS] && !go[NS]);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   // ---------------- stage 1: input register
   vsc_req_type req_ff;
   always_ff @(posedge clock) begin
      if (en[1]) req_ff <= req_data;
   end

   // ---------------- stage 2: nine products, row r word c
   logic signed [PROD_W-1:0] prod_ff [3][4];
   logic signed [GRID_W:0]   gx, gy, gz;
   assign gx = $signed({1'b0, req_ff.voxel_x});
   assign gy = $signed({1'b0, req_ff.voxel_y});
   assign gz = $signed({1'b0, req_ff.voxel_z});

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= $signed(coef_ff[2*r][COEF_W-1:0])
                             * $signed(gx[GRID_W:0]);
            prod_ff[r][1] <= $signed(coef_ff[2*r][2*COEF_W-1:COEF_W])
                             * $signed(gy[GRID_W:0]);
            prod_ff[r][2] <= $signed(coef_ff[2*r+1][COEF_W-1:0])
                             * $signed(gz[GRID_W:0]);
            prod_ff[r][3] <= PROD_W'($signed(coef_ff[2*r+1][2*COEF_W-1:COEF_W]));
         end
      end
   end

   // ---------------- stage 3: row sums
   logic signed [SUM_W-1:0] sum_in [3];
   logic signed [SUM_W-1:0] sum_ff [3];
   always_comb begin
      for (int r = 0; r < 3; r++)
         sum_in[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                   + SUM_W'(prod_ff[r][2]) + SUM_W'(prod_ff[r][3]);
   end
   always_ff @(posedge clock) begin
      if (en[ST_SUM]) sum_ff <= sum_in;
   end

   // ---------------- stage 4: 2*q + depth over 2*depth, positive divisor
   logic signed [NUM_W:0] na_s, nb_s, dd_s, na_n, nb_n, dd_n;
   logic                  dneg;
   logic                  neg_a_ff, neg_b_ff;
   logic [NUM_W-1:0]      num_a_ff, num_b_ff;
   logic [DEN_W-1:0]      den_ff;

   always_comb begin
      dneg = sum_ff[2][SUM_W-1];
      na_s = ((NUM_W+1)'(sum_ff[0]) <<< 1) + (NUM_W+1)'(sum_ff[2]);
      nb_s = ((NUM_W+1)'(sum_ff[1]) <<< 1) + (NUM_W+1)'(sum_ff[2]);
      dd_s = (NUM_W+1)'(sum_ff[2]) <<< 1;
      na_n = dneg ? -na_s : na_s;
      nb_n = dneg ? -nb_s : nb_s;
      dd_n = dneg ? -dd_s : dd_s;
   end

   always_ff @(posedge clock) begin
      if (en[ST_NORM]) begin
         neg_a_ff <= na_n[NUM_W];
         neg_b_ff <= nb_n[NUM_W];
         num_a_ff <= na_n[NUM_W-1:0];
         num_b_ff <= nb_n[NUM_W-1:0];
         den_ff   <= dd_n[DEN_W-1:0];
      end
   end

   // ---------------- stages 5..14: rounded quotients
   logic [QUO_W-1:0] col_q, row_q;
   logic             col_over, row_over;

   vsc_qdiv u_div_col (
      .clock   (clock),
      .load    (en[ST_ADDR-1:ST_DIV0]),
      .num_neg (neg_a_ff),
      .num     (num_a_ff),
      .den     (den_ff),
      .quo     (col_q),
      .over    (col_over)
   );

   vsc_qdiv u_div_row (
      .clock   (clock),
      .load    (en[ST_ADDR-1:ST_DIV0]),
      .num_neg (neg_b_ff),
      .num     (num_b_ff),
      .den     (den_ff),
      .quo     (row_q),
      .over    (row_over)
   );

   // ---------------- stage 15: bounds and store address
   logic                  in_bounds;
   logic [2*DIM_W-1:0]    lin_addr;

   assign in_bounds = !col_over && !row_over && (col_q < cols_ff) && (row_q < rows_ff);
   assign lin_addr  = (2*DIM_W)'(row_q) + rows_ff * col_q;

   always_comb begin
      tag_in[2].carve    = req_ff.req_type;
      tag_in[2].dz       = 1'b0;
      tag_in[2].oov      = 1'b0;
      tag_in[2].addr     = req_ff.mask_addr;
      tag_in[2].mask_bit = req_ff.mask_bit;
      tag_in[2].voxel    = req_ff.voxel_in;
      for (int i = 3; i <= NS; i++) tag_in[i] = tag_ff[i-1];
      tag_in[ST_SUM].dz = (sum_in[2] == '0);
      if (tag_ff[ST_ADDR-1].carve) begin
         tag_in[ST_ADDR].oov  = !tag_ff[ST_ADDR-1].dz && !in_bounds;
         tag_in[ST_ADDR].addr = lin_addr[STORE_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 2; i <= NS; i++)
         if (en[i]) tag_ff[i] <= tag_in[i];
   end

   // ---------------- stage 16: silhouette store, read-modify order kept
   logic store_mem [STORE_DEPTH];
   logic rd_ff;

   always_ff @(posedge clock) begin
      if (go[ST_MEM]) begin
         if (tag_ff[ST_MEM].carve) rd_ff <= store_mem[tag_ff[ST_MEM].addr];
         else store_mem[tag_ff[ST_MEM].addr] <= tag_ff[ST_MEM].mask_bit;
      end
   end

   // ---------------- stage 17: output register
   assign rsp_valid             = valid_ff[NS];
   assign rsp_data.voxel_out    = (tag_ff[NS].dz || (!tag_ff[NS].oov && rd_ff))
                                  ? tag_ff[NS].voxel : '0;
   assign rsp_data.out_of_view  = tag_ff[NS].oov;
   assign rsp_data.depth_zero   = tag_ff[NS].dz;

   // ---------------- checks
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.out_of_view && rsp_data.depth_zero))
      else $error("out_of_view and depth_zero both set");

   a_oov_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_view) |-> (rsp_data.voxel_out == '0))
      else $error("out-of-view voxel not cleared");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (valid_ff[1] && valid_ff[2]))
      else $error("input stalled with free stage");

endmodule

### tb/tb_voxel_silhouette_carve_top.sv
module tb_voxel_silhouette_carve_top;
   import vsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Q16.16 one, used to build camera matrices
   localparam int ONE_Q = 1 << 16;
   // cycles that can pass without any transaction before the run is abandoned
   localparam int WATCHDOG_LIMIT = 4000;
   // pipeline drain allowance
   localparam int DRAIN_CYCLES = 24;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   vsc_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   vsc_rsp_type           rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   voxel_silhouette_carve_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Mirror of the block's registers and silhouette store, updated on
   // each accepted transaction.
   logic [63:0]      camera_coef [COEF_REGS];
   logic [DIM_W-1:0] mask_cols_q;
   logic [DIM_W-1:0] mask_rows_q;
   bit               silhouette [STORE_DEPTH];
   // stimulus-side record of store bits that have been written
   bit               bit_written [STORE_DEPTH];

   vsc_req_type pending_reqs[$];
   vsc_rsp_type carve_results[$];

   int mismatch_count;
   int watchdog_count;

   // ---------------------------------------------------------------------
   // Projection arithmetic
   // ---------------------------------------------------------------------
   function automatic longint q_word(logic [31:0] w);
      return longint'(signed'(w));
   endfunction

   function automatic longint project_row(int r, longint x, longint y, longint z);
      logic [63:0] a;
      logic [63:0] b;
      a = camera_coef[2*r];
      b = camera_coef[2*r+1];
      return q_word(a[31:0]) * x + q_word(a[63:32]) * y +
             q_word(b[31:0]) * z + q_word(b[63:32]);
   endfunction

   // floor(num/den + 1/2); SV division truncates, so fix up negatives
   function automatic longint round_quotient(longint num, longint den);
      longint n;
      longint d;
      longint q;
      n = 2 * num + den;
      d = 2 * den;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   // Projects one voxel: flags zero depth / out of view, gives store address.
   task automatic locate_pixel(input logic [GRID_W-1:0] vx, input logic [GRID_W-1:0] vy,
                               input logic [GRID_W-1:0] vz, output bit dz,
                               output bit oov, output int unsigned addr);
      longint x;
      longint y;
      longint z;
      longint depth;
      longint col;
      longint row;
      x = longint'(vx);
      y = longint'(vy);
      z = longint'(vz);
      dz = 1'b0;
      oov = 1'b0;
      addr = 0;
      depth = project_row(2, x, y, z);
      if (depth == 0) begin
         dz = 1'b1;
      end else begin
         col = round_quotient(project_row(0, x, y, z), depth);
         row = round_quotient(project_row(1, x, y, z), depth);
         if (col < 0 || col >= longint'(mask_cols_q) ||
             row < 0 || row >= longint'(mask_rows_q)) begin
            oov = 1'b1;
         end else begin
            addr = int'((row + longint'(mask_rows_q) * col) % STORE_DEPTH);
         end
      end
   endtask

   // Expected outcome of one carve transaction.
   task automatic carve_outcome(input vsc_req_type rq, output vsc_rsp_type rs);
      bit dz;
      bit oov;
      int unsigned addr;
      locate_pixel(rq.voxel_x, rq.voxel_y, rq.voxel_z, dz, oov, addr);
      rs.depth_zero  = dz;
      rs.out_of_view = oov;
      if (dz) rs.voxel_out = rq.voxel_in;
      else if (oov) rs.voxel_out = '0;
      else rs.voxel_out = silhouette[addr] ? rq.voxel_in : 8'h00;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------
   task automatic add_mask_write(input int unsigned addr, input bit value);
      vsc_req_type rq;
      rq = '0;
      rq.req_type  = 1'b0;
      rq.mask_addr = addr[15:0];
      rq.mask_bit  = value;
      // unused fields carry noise
      rq.voxel_x   = GRID_W'($urandom);
      rq.voxel_in  = 8'($urandom);
      bit_written[addr[15:0]] = 1'b1;
      pending_reqs.push_back(rq);
   endtask

   // Queues a carve; a store bit it would read unwritten gets written first.
   // Registers do not change while a phase is queued, so the mirror is valid.
   task automatic add_carve(input int vx, input int vy, input int vz, input int vin);
      vsc_req_type rq;
      bit dz;
      bit oov;
      int unsigned addr;
      rq = '0;
      rq.req_type  = 1'b1;
      rq.voxel_x   = GRID_W'(vx);
      rq.voxel_y   = GRID_W'(vy);
      rq.voxel_z   = GRID_W'(vz);
      rq.voxel_in  = 8'(vin);
      rq.mask_addr = 16'($urandom);
      rq.mask_bit  = 1'($urandom);
      locate_pixel(rq.voxel_x, rq.voxel_y, rq.voxel_z, dz, oov, addr);
      if (!dz && !oov && !bit_written[addr]) add_mask_write(addr, 1'($urandom));
      pending_reqs.push_back(rq);
   endtask

   // One register write; returns only after acceptance, when the mirror
   // has already taken the new value.
   task automatic write_reg(input vsc_csr_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until all queued transactions are through, then lets the pipe
   // drain of trailing mask writes before registers may change.
   task automatic drain;
      while (pending_reqs.size() != 0 || req_valid || carve_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coef(int span);
      if ($urandom_range(0, 5) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // Random but mostly sensible camera: depth a signed constant with small tilt
   // (or a z plane if depth_plane), column/row terms spread over the mask.
   task automatic random_camera(input bit depth_plane);
      logic [31:0] dconst;
      logic [31:0] dz_coef;
      int          sgn;
      sgn = $urandom_range(0, 1) ? -1 : 1;
      write_reg(CSR_COEF_R0A, {rand_coef(ONE_Q / 4), rand_coef(4 * ONE_Q)});
      write_reg(CSR_COEF_R0B, {32'($urandom_range(0, 160) * ONE_Q * sgn),
                               rand_coef(ONE_Q / 4)});
      write_reg(CSR_COEF_R1A, {rand_coef(4 * ONE_Q), rand_coef(ONE_Q / 4)});
      write_reg(CSR_COEF_R1B, {32'($urandom_range(0, 160) * ONE_Q * sgn),
                               rand_coef(ONE_Q / 4)});
      if (depth_plane) begin
         // depth = (z - k): zero on one z plane
         dz_coef = 32'(ONE_Q);
         dconst  = 32'(-$urandom_range(0, 15) * ONE_Q);
         write_reg(CSR_COEF_R2A, 64'h0);
      end else begin
         dz_coef = 32'($signed($urandom_range(0, 64)) - 32);
         dconst  = 32'($urandom_range(1, 8) * ONE_Q * sgn + $urandom_range(0, 255));
         write_reg(CSR_COEF_R2A, {32'($signed($urandom_range(0, 64)) - 32),
                                  32'($signed($urandom_range(0, 64)) - 32)});
      end
      write_reg(CSR_COEF_R2B, {dconst, dz_coef});
   endtask

   task automatic random_items(input int count, input bit near_plane);
      int n;
      int vz;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 3) begin
            add_mask_write($urandom_range(0, STORE_DEPTH - 1), 1'($urandom));
         end else if ($urandom_range(0, 9) < 7) begin
            vz = near_plane ? $urandom_range(0, 15) : $urandom_range(0, 63);
            add_carve($urandom_range(0, 63), $urandom_range(0, 63), vz, $urandom);
         end else begin
            add_carve($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------
   initial begin
      int p;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset registers: all coefficients zero, so every carve hits zero depth
      add_mask_write(0, 1'b1);
      add_mask_write(STORE_DEPTH - 1, 1'b0);
      add_carve(0, 0, 0, 8'hA5);
      add_carve(1023, 1023, 1023, 8'hFF);
      add_carve(512, 341, 170, 8'h00);
      drain();

      // col = x/2, row = y/2, depth 1: exercises half-way rounding upward
      write_reg(CSR_COEF_R0A, {32'h0, 32'(ONE_Q / 2)});
      write_reg(CSR_COEF_R0B, 64'h0);
      write_reg(CSR_COEF_R1A, {32'(ONE_Q / 2), 32'h0});
      write_reg(CSR_COEF_R1B, 64'h0);
      write_reg(CSR_COEF_R2A, 64'h0);
      write_reg(CSR_COEF_R2B, {32'(ONE_Q), 32'h0});
      write_reg(CSR_MASK_COLS, 64'd256);
      write_reg(CSR_MASK_ROWS, 64'd256);
      add_carve(0, 0, 0, 8'hFF);
      add_carve(1, 1, 0, 8'h81);
      add_carve(3, 2, 5, 8'h7E);
      add_carve(510, 510, 0, 8'h01);
      add_carve(511, 0, 0, 8'h55);      // col rounds to 256: just off the edge
      add_carve(1023, 1023, 1023, 8'hFF);
      add_mask_write(16'h0101, 1'b0);
      add_carve(2, 2, 0, 8'h33);        // pixel (1,1) after a clear
      drain();

      // negative depth with negative numerator, offsets of plus and minus one half
      write_reg(CSR_COEF_R0A, {32'h0, 32'(-ONE_Q / 2)});
      write_reg(CSR_COEF_R0B, {32'(ONE_Q / 2), 32'h0});
      write_reg(CSR_COEF_R1A, {32'(-ONE_Q), 32'h0});
      write_reg(CSR_COEF_R1B, {32'(-ONE_Q / 2), 32'h0});
      write_reg(CSR_COEF_R2B, {32'(-ONE_Q), 32'h0});
      add_carve(1, 0, 0, 8'hC3);
      add_carve(3, 1, 0, 8'h3C);
      add_carve(0, 1, 0, 8'h99);
      drain();

      // extreme coefficients and an empty mask: everything out of view
      write_reg(CSR_COEF_R0A, 64'h8000_0000_7FFF_FFFF);
      write_reg(CSR_COEF_R0B, 64'hFFFF_FFFF_8000_0000);
      write_reg(CSR_COEF_R1A, 64'h7FFF_FFFF_FFFF_FFFF);
      write_reg(CSR_COEF_R1B, 64'h8000_0000_8000_0000);
      write_reg(CSR_COEF_R2A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_COEF_R2B, 64'h7FFF_FFFF_7FFF_FFFF);
      write_reg(CSR_MASK_COLS, 64'h0);
      write_reg(CSR_MASK_ROWS, 64'hFFFF_FFFF_FFFF_FE00);  // upper bits ignored
      add_carve(1023, 1023, 1023, 8'hFF);
      add_carve(0, 0, 0, 8'hFF);
      add_carve(1, 0, 0, 8'h12);
      drain();

      // random phases with varying mask extents
      for (p = 0; p < 6; p++) begin
         random_camera(p == 2);
         case (p)
            0: begin
               write_reg(CSR_MASK_COLS, 64'd256);
               write_reg(CSR_MASK_ROWS, 64'd256);
            end
            1: begin
               write_reg(CSR_MASK_COLS, 64'd1);
               write_reg(CSR_MASK_ROWS, 64'd256);
            end
            3: begin
               write_reg(CSR_MASK_COLS, 64'd256);
               write_reg(CSR_MASK_ROWS, 64'd1);
            end
            default: begin
               write_reg(CSR_MASK_COLS, 64'($urandom_range(0, 256)));
               write_reg(CSR_MASK_ROWS, 64'($urandom_range(0, 256)));
            end
         endcase
         random_items(60, p == 2);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps
   // ---------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: spans of always-ready, random, and fully stalled
   // ---------------------------------------------------------------------
   int stall_mode;
   int stall_span;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_mode <= 0;
         stall_span <= 0;
      end else begin
         if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(4, 60);
         end else begin
            stall_span <= stall_span - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom);
            default: rsp_ready <= 1'b0;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: mirror register writes, predict carves, check results
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      vsc_rsp_type want;
      if (reset) begin
         for (int i = 0; i < COEF_REGS; i++) camera_coef[i] = '0;
         mask_cols_q = DIM_RESET;
         mask_rows_q = DIM_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (vsc_csr_type'(csr_index))
               CSR_MASK_COLS: mask_cols_q = csr_data[DIM_W-1:0];
               CSR_MASK_ROWS: mask_rows_q = csr_data[DIM_W-1:0];
               default: camera_coef[csr_index] = csr_data;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.req_type) begin
               carve_outcome(req_data, want);
               carve_results.push_back(want);
            end else begin
               silhouette[req_data.mask_addr] = req_data.mask_bit;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (carve_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result transaction %p", $realtime, rsp_data);
            end else begin
               want = carve_results.pop_front();
               if (rsp_data.voxel_out !== want.voxel_out ||
                   rsp_data.out_of_view !== want.out_of_view ||
                   rsp_data.depth_zero !== want.depth_zero) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch: expected voxel %h oov %b dz %b, got voxel %h oov %b dz %b",
                              $realtime, want.voxel_out, want.out_of_view, want.depth_zero,
                              rsp_data.voxel_out, rsp_data.out_of_view, rsp_data.depth_zero);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         watchdog_count <= 0;
      end else if (watchdog_count >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         watchdog_count <= watchdog_count + 1;
      end
   end

endmodule

### voxel_silhouette_carve_top.f
sv/vsc_pkg.sv
sv/vsc_qdiv.sv
sv/voxel_silhouette_carve_top.sv
tb/tb_voxel_silhouette_carve_top.sv
